// ----- rtl/stl_pkg.sv -----
// Package: token kinds, scan modes, shared types and helper functions for the lexer.
`timescale 1ns / 1ps
package stl_pkg;

   localparam int SourceMaxBytesDefault = 65536;

   // token kinds
   localparam logic [5:0] KIND_DOT        = 6'd5;
   localparam logic [5:0] KIND_SLASH      = 6'd9;
   localparam logic [5:0] KIND_IDENT      = 6'd19;
   localparam logic [5:0] KIND_STRING     = 6'd20;
   localparam logic [5:0] KIND_NUMBER     = 6'd21;
   localparam logic [5:0] KIND_END        = 6'd38;
   localparam logic [5:0] KIND_BADCHAR    = 6'd39;
   localparam logic [5:0] KIND_BADSTRING  = 6'd40;

   // scan modes
   localparam logic [3:0] MODE_IDLE    = 4'd0;
   localparam logic [3:0] MODE_OPER    = 4'd1;
   localparam logic [3:0] MODE_SLASH   = 4'd2;
   localparam logic [3:0] MODE_COMMENT = 4'd3;
   localparam logic [3:0] MODE_STRING  = 4'd4;
   localparam logic [3:0] MODE_NUMBER  = 4'd5;
   localparam logic [3:0] MODE_NUMDOT  = 4'd6;
   localparam logic [3:0] MODE_FRAC    = 4'd7;
   localparam logic [3:0] MODE_WORD    = 4'd8;

   localparam int MaxTokens = 4;
   localparam int QueueDepth = 4;

   // token as it leaves the lexer
   typedef struct packed {
      logic [5:0]  kind;
      logic [15:0] start;
      logic [15:0] length;
      logic [15:0] line;
      logic        last;
   } token_type;

   // all tokens one byte causes (front to back)
   typedef struct packed {
      logic [2:0]                    count;
      token_type [MaxTokens-1:0]     tok;
   } bundle_type;

   function automatic logic digit_char(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic word_start_char(input logic [7:0] c);
      return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a)) ||
             (c == 8'h5f);
   endfunction

   // saturating span to-from, zero when negative
   function automatic logic [15:0] span(input logic [15:0] from, input logic [16:0] to);
      logic [16:0] d;
      d = (to > {1'b0, from}) ? to - {1'b0, from} : 17'd0;
      return d[16] ? 16'hffff : d[15:0];
   endfunction

   // operator base kind: ! = < >
   function automatic logic [5:0] oper_kind(input logic [1:0] op);
      logic [5:0] k;
      unique case (op)
         2'd0: k = 6'd11;
         2'd1: k = 6'd13;
         2'd2: k = 6'd17;
         default: k = 6'd15;
      endcase
      return k;
   endfunction

   // keyword lookup on packed prefix
   function automatic logic [5:0] word_kind(input logic [47:0] w, input logic [2:0] n);
      logic [5:0] k;
      k = KIND_IDENT;
      unique case (n)
         3'd2: begin
            if (w[15:0] == "if") k = 6'd28;
            if (w[15:0] == "or") k = 6'd30;
         end
         3'd3: begin
            if (w[23:0] == "and") k = 6'd22;
            if (w[23:0] == "fun") k = 6'd26;
            if (w[23:0] == "for") k = 6'd27;
            if (w[23:0] == "nil") k = 6'd29;
            if (w[23:0] == "var") k = 6'd36;
         end
         3'd4: begin
            if (w[31:0] == "else") k = 6'd24;
            if (w[31:0] == "this") k = 6'd34;
            if (w[31:0] == "true") k = 6'd35;
         end
         3'd5: begin
            if (w[39:0] == "class") k = 6'd23;
            if (w[39:0] == "false") k = 6'd25;
            if (w[39:0] == "print") k = 6'd31;
            if (w[39:0] == "super") k = 6'd33;
            if (w[39:0] == "while") k = 6'd37;
         end
         3'd6: begin
            if (w == "return") k = 6'd32;
         end
         default: k = KIND_IDENT;
      endcase
      return k;
   endfunction

endpackage

// ----- rtl/stl_if.sv -----
// Interfaces: valid/ready channels for source bytes and tokens.
`timescale 1ns / 1ps
interface stl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       final_byte;
   modport source (output valid, output text_byte, output final_byte, input ready);
   modport sink (input valid, input text_byte, input final_byte, output ready);
endinterface

interface stl_rsp_if;
   logic        valid;
   logic        ready;
   logic [5:0]  token_kind;
   logic [15:0] token_start;
   logic [15:0] token_length;
   logic [15:0] token_line;
   logic        run_last;
   modport source (output valid, output token_kind, output token_start, output token_length,
                   output token_line, output run_last, input ready);
   modport sink (input valid, input token_kind, input token_start, input token_length,
                 input token_line, input run_last, output ready);
endinterface

// ----- rtl/stl_front.sv -----
// Front end: scan state machine, one byte per cycle while take is high, builds the token bundle of each byte.
`timescale 1ns / 1ps
module stl_front #(
   parameter int SOURCE_MAX_BYTES = stl_pkg::SourceMaxBytesDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 take,
   input  logic [7:0]           text_byte,
   input  logic                 final_byte,
   output stl_pkg::bundle_type  bundle
);
   localparam logic [15:0] OffsetCap = (SOURCE_MAX_BYTES - 1 < 65535) ?
                                       16'(SOURCE_MAX_BYTES - 1) : 16'hffff;

   logic [3:0]  mode_ff, mode_in;
   logic [1:0]  op_ff, op_in;
   logic [15:0] offset_ff, offset_in;
   logic [15:0] start_ff, start_in;
   logic [15:0] line_ff, line_in;
   logic [47:0] word_ff, word_in;
   logic [2:0]  wlen_ff, wlen_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= stl_pkg::MODE_IDLE;
         op_ff     <= 2'd0;
         offset_ff <= 16'd0;
         start_ff  <= 16'd0;
         line_ff   <= 16'd1;
         word_ff   <= 48'd0;
         wlen_ff   <= 3'd0;
      end else if (take) begin
         mode_ff   <= mode_in;
         op_ff     <= op_in;
         offset_ff <= offset_in;
         start_ff  <= start_in;
         line_ff   <= line_in;
         word_ff   <= word_in;
         wlen_ff   <= wlen_in;
      end
   end

   // next state and emitted tokens for the current byte
   always_comb begin
      logic [7:0]  c;
      logic [15:0] p;
      logic [16:0] p1;
      logic        redo;
      logic [15:0] dot;
      logic [2:0]  n;
      logic [2:0]  n_first;
      logic [5:0]  opk;
      stl_pkg::token_type t;
      c = text_byte;
      p = offset_ff;
      p1 = {1'b0, p} + 17'd1;
      redo = 1'b0;
      n = 3'd0;
      bundle = '0;
      mode_in = mode_ff;
      op_in = op_ff;
      start_in = start_ff;
      line_in = line_ff;
      word_in = word_ff;
      wlen_in = wlen_ff;
      opk = stl_pkg::oper_kind(op_ff);
      dot = (p != 16'd0) ? p - 16'd1 : 16'd0;
      t = '0;

      unique case (mode_ff)
         stl_pkg::MODE_OPER: begin
            if (c == "=") begin
               t = '{opk + 6'd1, start_ff, stl_pkg::span(start_ff, p1), 16'd0, 1'b0};
               bundle.tok[n[1:0]] = t; n = n + 3'd1;
               mode_in = stl_pkg::MODE_IDLE;
            end else begin
               t = '{opk, start_ff, 16'd1, 16'd0, 1'b0};
               bundle.tok[n[1:0]] = t; n = n + 3'd1;
               redo = 1'b1;
            end
         end
         stl_pkg::MODE_SLASH: begin
            if (c == "/") mode_in = stl_pkg::MODE_COMMENT;
            else begin
               t = '{stl_pkg::KIND_SLASH, start_ff, 16'd1, 16'd0, 1'b0};
               bundle.tok[n[1:0]] = t; n = n + 3'd1;
               redo = 1'b1;
            end
         end
         stl_pkg::MODE_COMMENT: begin
            if (c == 8'h0a) redo = 1'b1;
         end
         stl_pkg::MODE_STRING: begin
            if (c == 8'h22) begin
               t = '{stl_pkg::KIND_STRING, start_ff, stl_pkg::span(start_ff, p1), 16'd0,
                     1'b0};
               bundle.tok[n[1:0]] = t; n = n + 3'd1;
               mode_in = stl_pkg::MODE_IDLE;
            end else if (c == 8'h0a && line_in != 16'hffff) line_in = line_in + 16'd1;
         end
         stl_pkg::MODE_NUMBER: begin
            if (c == ".") mode_in = stl_pkg::MODE_NUMDOT;
            else if (!stl_pkg::digit_char(c)) begin
               t = '{stl_pkg::KIND_NUMBER, start_ff, stl_pkg::span(start_ff, {1'b0, p}),
                     16'd0, 1'b0};
               bundle.tok[n[1:0]] = t; n = n + 3'd1;
               redo = 1'b1;
            end
         end
         stl_pkg::MODE_NUMDOT: begin
            if (stl_pkg::digit_char(c)) mode_in = stl_pkg::MODE_FRAC;
            else begin
               t = '{stl_pkg::KIND_NUMBER, start_ff, stl_pkg::span(start_ff, {1'b0, dot}),
                     16'd0, 1'b0};
               bundle.tok[n[1:0]] = t; n = n + 3'd1;
               t = '{stl_pkg::KIND_DOT, dot, 16'd1, 16'd0, 1'b0};
               bundle.tok[n[1:0]] = t; n = n + 3'd1;
               redo = 1'b1;
            end
         end
         stl_pkg::MODE_FRAC: begin
            if (!stl_pkg::digit_char(c)) begin
               t = '{stl_pkg::KIND_NUMBER, start_ff, stl_pkg::span(start_ff, {1'b0, p}),
                     16'd0, 1'b0};
               bundle.tok[n[1:0]] = t; n = n + 3'd1;
               redo = 1'b1;
            end
         end
         stl_pkg::MODE_WORD: begin
            if (stl_pkg::word_start_char(c) || stl_pkg::digit_char(c)) begin
               if (wlen_ff < 3'd6) begin
                  word_in = {word_ff[39:0], c};
                  wlen_in = wlen_ff + 3'd1;
               end else wlen_in = 3'd7;
            end else begin
               t = '{stl_pkg::word_kind(word_ff, wlen_ff), start_ff,
                     stl_pkg::span(start_ff, {1'b0, p}), 16'd0, 1'b0};
               bundle.tok[n[1:0]] = t; n = n + 3'd1;
               redo = 1'b1;
            end
         end
         default: redo = 1'b1;
      endcase
      n_first = n;

      // byte seen with no token open
      if (redo) begin
         mode_in = stl_pkg::MODE_IDLE;
         start_in = p;
         t = '{6'd0, p, 16'd1, 16'd0, 1'b0};
         unique case (c)
            "(": begin t.kind = 6'd0;  bundle.tok[n[1:0]] = t; n = n + 3'd1; end
            ")": begin t.kind = 6'd1;  bundle.tok[n[1:0]] = t; n = n + 3'd1; end
            "{": begin t.kind = 6'd2;  bundle.tok[n[1:0]] = t; n = n + 3'd1; end
            "}": begin t.kind = 6'd3;  bundle.tok[n[1:0]] = t; n = n + 3'd1; end
            ",": begin t.kind = 6'd4;  bundle.tok[n[1:0]] = t; n = n + 3'd1; end
            ".": begin t.kind = stl_pkg::KIND_DOT; bundle.tok[n[1:0]] = t; n = n + 3'd1; end
            "-": begin t.kind = 6'd6;  bundle.tok[n[1:0]] = t; n = n + 3'd1; end
            "+": begin t.kind = 6'd7;  bundle.tok[n[1:0]] = t; n = n + 3'd1; end
            ";": begin t.kind = 6'd8;  bundle.tok[n[1:0]] = t; n = n + 3'd1; end
            "*": begin t.kind = 6'd10; bundle.tok[n[1:0]] = t; n = n + 3'd1; end
            "!": begin mode_in = stl_pkg::MODE_OPER; op_in = 2'd0; end
            "=": begin mode_in = stl_pkg::MODE_OPER; op_in = 2'd1; end
            "<": begin mode_in = stl_pkg::MODE_OPER; op_in = 2'd2; end
            ">": begin mode_in = stl_pkg::MODE_OPER; op_in = 2'd3; end
            "/": mode_in = stl_pkg::MODE_SLASH;
            8'h20, 8'h0d, 8'h09: ;
            8'h0a: if (line_in != 16'hffff) line_in = line_in + 16'd1;
            8'h22: mode_in = stl_pkg::MODE_STRING;
            default: begin
               if (stl_pkg::digit_char(c)) mode_in = stl_pkg::MODE_NUMBER;
               else if (stl_pkg::word_start_char(c)) begin
                  mode_in = stl_pkg::MODE_WORD;
                  word_in = {40'd0, c};
                  wlen_in = 3'd1;
               end else begin
                  t.kind = stl_pkg::KIND_BADCHAR;
                  bundle.tok[n[1:0]] = t; n = n + 3'd1;
               end
            end
         endcase
      end

      // end of source: flush open token, then end token, then reset state
      if (final_byte) begin
         unique case (mode_in)
            stl_pkg::MODE_OPER: begin
               t = '{stl_pkg::oper_kind(op_in), start_in, 16'd1, 16'd0, 1'b0};
               bundle.tok[n[1:0]] = t; n = n + 3'd1;
            end
            stl_pkg::MODE_SLASH: begin
               t = '{stl_pkg::KIND_SLASH, start_in, 16'd1, 16'd0, 1'b0};
               bundle.tok[n[1:0]] = t; n = n + 3'd1;
            end
            stl_pkg::MODE_STRING: begin
               t = '{stl_pkg::KIND_BADSTRING, start_in, stl_pkg::span(start_in, p1),
                     16'd0, 1'b0};
               bundle.tok[n[1:0]] = t; n = n + 3'd1;
            end
            stl_pkg::MODE_NUMBER, stl_pkg::MODE_FRAC: begin
               t = '{stl_pkg::KIND_NUMBER, start_in, stl_pkg::span(start_in, p1),
                     16'd0, 1'b0};
               bundle.tok[n[1:0]] = t; n = n + 3'd1;
            end
            stl_pkg::MODE_NUMDOT: begin
               t = '{stl_pkg::KIND_NUMBER, start_in, stl_pkg::span(start_in, {1'b0, p}),
                     16'd0, 1'b0};
               bundle.tok[n[1:0]] = t; n = n + 3'd1;
               t = '{stl_pkg::KIND_DOT, p, 16'd1, 16'd0, 1'b0};
               bundle.tok[n[1:0]] = t; n = n + 3'd1;
            end
            stl_pkg::MODE_WORD: begin
               t = '{stl_pkg::word_kind(word_in, wlen_in), start_in,
                     stl_pkg::span(start_in, p1), 16'd0, 1'b0};
               bundle.tok[n[1:0]] = t; n = n + 3'd1;
            end
            default: ;
         endcase
         t = '{stl_pkg::KIND_END, (p1 > {1'b0, OffsetCap}) ? OffsetCap : p1[15:0],
               16'd0, 16'd0, 1'b0};
         bundle.tok[n[1:0]] = t; n = n + 3'd1;
      end

      // tokens closed by the byte keep the old line; later ones see this byte's newline
      for (int i = 0; i < stl_pkg::MaxTokens; i++) begin
         bundle.tok[i].line = (3'(i) < n_first) ? line_ff : line_in;
         bundle.tok[i].last = (3'(i) + 3'd1 == n);
      end
      bundle.count = n;

      if (final_byte) begin
         mode_in = stl_pkg::MODE_IDLE;
         op_in = 2'd0;
         offset_in = 16'd0;
         start_in = 16'd0;
         line_in = 16'd1;
         word_in = 48'd0;
         wlen_in = 3'd0;
      end else begin
         offset_in = (p1 > {1'b0, OffsetCap}) ? OffsetCap : p1[15:0];
      end
   end

endmodule

// ----- rtl/stl_back.sv -----
// Back end: queue of token bundles, serialized one token per beat onto the result channel.
`timescale 1ns / 1ps
module stl_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  stl_pkg::bundle_type bundle,
   output logic                has_room,
   stl_rsp_if.source           rsp
);
   localparam int PtrBits = $clog2(stl_pkg::QueueDepth);

   stl_pkg::bundle_type           queue_ff [stl_pkg::QueueDepth];
   logic [PtrBits-1:0]            wr_ff, rd_ff;
   logic [PtrBits:0]              fill_ff;
   logic [1:0]                    sub_ff;
   stl_pkg::token_type            head;
   logic                          pop_tok, pop_bundle, push_q;

   // bundles with no tokens never enter the queue
   assign push_q     = push && (bundle.count != 3'd0);
   assign has_room   = (fill_ff != (PtrBits+1)'(stl_pkg::QueueDepth));
   assign head       = queue_ff[rd_ff].tok[sub_ff];
   assign rsp.valid  = (fill_ff != '0);
   assign pop_tok    = rsp.valid && rsp.ready;
   assign pop_bundle = pop_tok && ({1'b0, sub_ff} + 3'd1 == queue_ff[rd_ff].count);

   assign rsp.token_kind   = head.kind;
   assign rsp.token_start  = head.start;
   assign rsp.token_length = head.length;
   assign rsp.token_line   = head.line;
   assign rsp.run_last     = head.last;

   always_ff @(posedge clock) begin
      if (push_q) queue_ff[wr_ff] <= bundle;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         fill_ff <= '0;
         sub_ff  <= 2'd0;
      end else begin
         if (push_q) wr_ff <= wr_ff + 1'b1;
         if (pop_bundle) begin
            rd_ff  <= rd_ff + 1'b1;
            sub_ff <= 2'd0;
         end else if (pop_tok) sub_ff <= sub_ff + 2'd1;
         fill_ff <= fill_ff + (PtrBits+1)'(push_q) - (PtrBits+1)'(pop_bundle);
      end
   end

endmodule

// ----- rtl/source_token_lexer_top.sv -----
// Top level: streaming lexer, byte channel in, token channel out.
`timescale 1ns / 1ps
// One source byte is taken per clock. The front end resolves the byte against the
// scan state in that same cycle; any tokens it completes (up to four) are written
// as one entry into a four-entry queue; the back end sends one token per beat.
// Input throughput is one byte per cycle as long as the queue has room, so the
// sustained rate is set by the token port: a byte that yields k tokens costs k
// output beats. Results appear at the earliest in the cycle after the byte.
module source_token_lexer_top #(
   parameter int SOURCE_MAX_BYTES = stl_pkg::SourceMaxBytesDefault
) (
   input logic       clock,
   input logic       reset,
   stl_req_if.sink   req,
   stl_rsp_if.source rsp
);
   stl_pkg::bundle_type bundle;
   logic                has_room, take;

   assign req.ready = has_room;
   assign take      = req.valid && req.ready;

   stl_front #(.SOURCE_MAX_BYTES(SOURCE_MAX_BYTES)) u_front (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .text_byte  (req.text_byte),
      .final_byte (req.final_byte),
      .bundle     (bundle)
   );

   stl_back u_back (
      .clock    (clock),
      .reset    (reset),
      .push     (take),
      .bundle   (bundle),
      .has_room (has_room),
      .rsp      (rsp)
   );

   // a final byte always produces a token
   a_final_emits: assert property (@(posedge clock) disable iff (reset)
      take && req.final_byte |-> bundle.count != 3'd0)
      else $error("final byte produced no token");

   // no byte causes more than four tokens
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      take |-> bundle.count <= 3'd4)
      else $error("token count out of range");

   // an end token always closes its run
   a_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.token_kind == stl_pkg::KIND_END |-> rsp.run_last)
      else $error("end token not last of run");

endmodule
